// ===== design/block_reduce_downsampler_macros.svh =====
// Assertion macros shared by the block reduce downsampler modules.
// No dependencies.
`ifndef BLOCK_REDUCE_DOWNSAMPLER_MACROS_SVH
`define BLOCK_REDUCE_DOWNSAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRD_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define BRD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BRD_ASSERT_IMP(label, clk, rst, a, c)
`define BRD_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/brd_pkg.sv =====
// Package for the block reduce downsampler: widths, codes, command and status structs.
// No dependencies.
package brd_pkg;
  localparam int MAX_TILE_WIDTH = 4096;
  localparam int MAX_BLOCK = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int ACC_BITS = 36;
  localparam int CFG_BITS = 13;
  localparam logic [1:0] REG_TILE_WIDTH = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0] REG_REDUCE_MODE = 2'd2;
  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;

  typedef struct packed {
    logic take;       // sample accepted, start read of accumulator
    logic first;      // first sample of its block
    logic emit;       // block completes with this sample
    logic bad;        // bad factor result
    logic last;
  } brd_cmd_t;

  typedef struct packed {
    logic busy;       // accumulate or divide in progress
    logic out_full;
  } brd_stat_t;
endpackage

// ===== design/brd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module brd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/brd_ctrl.sv =====
// Controller: tile and block position counters, block classification.
// Depends on brd_pkg and block_reduce_downsampler_macros.svh.
`include "block_reduce_downsampler_macros.svh"
module brd_ctrl #(
  parameter int MAX_TILE_WIDTH = brd_pkg::MAX_TILE_WIDTH,
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK,
  localparam int CW = $clog2(MAX_TILE_WIDTH) > 0 ? $clog2(MAX_TILE_WIDTH) : 1,
  localparam int BW = $clog2(MAX_BLOCK) > 0 ? $clog2(MAX_BLOCK) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_busy,
  input  logic [CW:0]              w,
  input  logic [BW:0]              bs,
  input  logic                     bad_factor,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  brd_pkg::brd_stat_t       stat,
  output brd_pkg::brd_cmd_t        cmd,
  output logic [CW-1:0]            oc,
  output logic [CW-1:0]            orow
);
  typedef enum logic [0:0] {S_RUN, S_WAIT} state_t;
  state_t state;
  logic [CW-1:0] in_column, in_row, bcol, brow;
  logic [BW-1:0] cib, rib;
  logic drop_tile;
  logic take, at_start, col_end, row_end, blk_col_end, blk_row_end;

  assign in_stall = (state != S_RUN) || cfg_busy || stat.busy || stat.out_full;
  assign take = in_valid && !in_stall;
  assign at_start = (in_column == '0) && (in_row == '0);
  assign col_end = ({1'b0, in_column} == w - 1'b1);
  assign row_end = ({1'b0, in_row} == w - 1'b1);
  assign blk_col_end = ({1'b0, cib} == bs - 1'b1);
  assign blk_row_end = ({1'b0, rib} == bs - 1'b1);
  assign oc = bcol;
  assign orow = brow;

  always_comb begin
    cmd = '0;
    cmd.bad = take && at_start && bad_factor;
    cmd.take = take && !cmd.bad && !drop_tile;
    cmd.first = (cib == '0) && (rib == '0);
    cmd.emit = cmd.take && blk_col_end && blk_row_end;
    cmd.last = cmd.bad || (col_end && row_end);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_RUN;
      in_column <= '0;
      in_row <= '0;
      bcol <= '0;
      brow <= '0;
      cib <= '0;
      rib <= '0;
      drop_tile <= 1'b0;
    end else begin
      // the S_WAIT state after each accepted beat lets the accumulator read-modify-write finish
      unique case (state)
        S_RUN: if (take) state <= S_WAIT;
        S_WAIT: state <= S_RUN;
        default: state <= S_RUN;
      endcase
      if (take) begin
        if (cmd.bad && !(col_end && row_end)) drop_tile <= 1'b1;
        if (col_end) begin
          in_column <= '0;
          cib <= '0;
          bcol <= '0;
          if (row_end) begin
            in_row <= '0;
            rib <= '0;
            brow <= '0;
            drop_tile <= 1'b0;
          end else begin
            in_row <= in_row + 1'b1;
            if (blk_row_end) begin
              rib <= '0;
              brow <= brow + 1'b1;
            end else begin
              rib <= rib + 1'b1;
            end
          end
        end else begin
          in_column <= in_column + 1'b1;
          if (blk_col_end) begin
            cib <= '0;
            bcol <= bcol + 1'b1;
          end else begin
            cib <= cib + 1'b1;
          end
        end
      end
    end
  end

  `BRD_ASSERT_NEXT(a_gap, clk, rst, take, in_stall)
  `BRD_ASSERT_IMP(a_emit_take, clk, rst, cmd.emit, cmd.take)
  `BRD_ASSERT_IMP(a_bad_start, clk, rst, cmd.bad, at_start)
endmodule

// ===== design/brd_dpath.sv =====
// Datapath: accumulator RAM, max/min/sum update, serial mean divider, output.
// Depends on brd_pkg, brd_ram and block_reduce_downsampler_macros.svh.
`include "block_reduce_downsampler_macros.svh"
module brd_dpath #(
  parameter int MAX_TILE_WIDTH = brd_pkg::MAX_TILE_WIDTH,
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK,
  parameter int SAMPLE_BITS = brd_pkg::SAMPLE_BITS,
  localparam int CW = $clog2(MAX_TILE_WIDTH) > 0 ? $clog2(MAX_TILE_WIDTH) : 1,
  localparam int BW = $clog2(MAX_BLOCK) > 0 ? $clog2(MAX_BLOCK) : 1,
  localparam int AW = SAMPLE_BITS + 2 * BW + 1,
  localparam int DW = 2 * BW + 2,
  localparam int QW = $clog2(AW + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    mode,
  input  logic [BW:0]                   bs,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  brd_pkg::brd_cmd_t             cmd,
  input  logic [CW-1:0]                 oc,
  input  logic [CW-1:0]                 orow,
  output brd_pkg::brd_stat_t            stat,
  output logic signed [SAMPLE_BITS-1:0] reduced_value,
  output logic [11:0]                   out_column,
  output logic [11:0]                   out_row,
  output logic                          status,
  output logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall
);
  logic upd, first_q, emit_q, last_q, div_busy;
  logic [CW-1:0] oc_q, orow_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [AW-1:0] rd, acc, s_ext;
  logic [AW-1:0] quo;
  logic [DW-1:0] rem, div, area;
  logic neg;
  logic [QW-1:0] cnt;
  logic [DW:0] trial;

  brd_ram #(.WIDTH(AW), .DEPTH(MAX_TILE_WIDTH)) u_acc (
    .clk(clk), .we(upd), .waddr(oc_q), .wdata(acc), .raddr(oc), .rdata(rd)
  );

  assign s_ext = AW'(s_q);
  assign area = DW'(bs) * DW'(bs);
  always_comb begin
    if (first_q) acc = s_ext;
    else if (mode == brd_pkg::MODE_MAX) acc = (s_ext > rd) ? s_ext : rd;
    else if (mode == brd_pkg::MODE_MIN) acc = (s_ext < rd) ? s_ext : rd;
    else acc = rd + s_ext;
  end
  assign trial = {rem, quo[AW-1]} - {1'b0, div};
  assign stat.busy = upd || div_busy;
  assign stat.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_q <= sample;
      first_q <= cmd.first;
      oc_q <= oc;
      orow_q <= orow;
      last_q <= cmd.last;
    end
    if (rst) begin
      upd <= 1'b0;
      emit_q <= 1'b0;
      div_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      upd <= cmd.take;
      emit_q <= cmd.emit;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.bad) begin
        out_valid <= 1'b1;
        reduced_value <= '0;
        out_column <= '0;
        out_row <= '0;
        status <= 1'b1;
        last <= 1'b1;
      end
      if (upd && emit_q) begin
        out_column <= 12'(oc_q);
        out_row <= 12'(orow_q);
        status <= 1'b0;
        last <= last_q;
        if (mode == brd_pkg::MODE_MAX || mode == brd_pkg::MODE_MIN) begin
          reduced_value <= SAMPLE_BITS'(acc);
          out_valid <= 1'b1;
        end else begin
          neg <= acc[AW-1];
          quo <= acc[AW-1] ? AW'(-acc) : AW'(acc);
          rem <= '0;
          div <= area;
          cnt <= QW'(AW);
          div_busy <= 1'b1;
        end
      end
      // restoring divider, one quotient bit per cycle
      if (div_busy) begin
        if (cnt == '0) begin
          div_busy <= 1'b0;
          out_valid <= 1'b1;
          reduced_value <= neg ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);
        end else begin
          cnt <= cnt - 1'b1;
          if (!trial[DW]) begin
            rem <= trial[DW-1:0];
            quo <= {quo[AW-2:0], 1'b1};
          end else begin
            rem <= {rem[DW-2:0], quo[AW-1]};
            quo <= {quo[AW-2:0], 1'b0};
          end
        end
      end
    end
  end

  `BRD_ASSERT_IMP(a_no_take_busy, clk, rst, cmd.take, !stat.busy && !out_valid)
  `BRD_ASSERT_IMP(a_div_alone, clk, rst, div_busy, !upd)
  `BRD_ASSERT_NEXT(a_upd_follows, clk, rst, cmd.take, upd)
endmodule

// ===== design/block_reduce_downsampler.sv =====
// Block reduce downsampler, top level: configuration registers, controller, datapath.
// Depends on brd_pkg, brd_ctrl, brd_dpath, brd_ram.
//
// Takes a square tile of signed 8-fraction-bit samples in raster order and
// reduces each block_size square block to its max, min or truncated mean,
// using one accumulator RAM entry per output column. Each sample is read
// from the RAM, then updated and written back, before the next is taken. A
// max or min result is registered from the update of the block's last
// sample; in mean mode the serial divider produces it from the block sum.
// Input is stalled meanwhile and while a result waits. After reset and
// after each configuration register write the input is stalled while the
// tile width is checked against the block size. A configuration write
// restarts the tile. A tile width not a multiple of the block size gives
// one status=1 beat and drops that tile.
module block_reduce_downsampler #(
  parameter int MAX_TILE_WIDTH = brd_pkg::MAX_TILE_WIDTH,
  parameter int MAX_BLOCK = brd_pkg::MAX_BLOCK,
  parameter int SAMPLE_BITS = brd_pkg::SAMPLE_BITS,
  localparam int CW = $clog2(MAX_TILE_WIDTH) > 0 ? $clog2(MAX_TILE_WIDTH) : 1,
  localparam int BW = $clog2(MAX_BLOCK) > 0 ? $clog2(MAX_BLOCK) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [brd_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] reduced_value,
  output logic [11:0]                   out_column,
  output logic [11:0]                   out_row,
  output logic                          status,
  output logic                          last
);
  localparam int RCW = $clog2(CW + 2);
  localparam int RIW = $clog2(CW + 1);

  logic [12:0] tile_width;
  logic [6:0] block_size;
  logic [1:0] reduce_mode;
  logic [CW:0] w;
  logic [BW:0] bs;
  logic bad_factor;
  logic [BW:0] rem_acc;
  logic [BW+1:0] rem_trial, rem_sub;
  logic [RCW-1:0] rem_cnt;
  logic [RIW-1:0] rem_bit;
  logic rem_busy;
  brd_pkg::brd_cmd_t cmd;
  brd_pkg::brd_stat_t stat;
  logic [CW-1:0] oc, orow;
  logic cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width <= 13'd4096;
      block_size <= 7'd2;
      reduce_mode <= brd_pkg::MODE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brd_pkg::REG_TILE_WIDTH: tile_width <= cfg_data;
        brd_pkg::REG_BLOCK_SIZE: block_size <= cfg_data[6:0];
        brd_pkg::REG_REDUCE_MODE: reduce_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == brd_pkg::REG_TILE_WIDTH) ||
                              (cfg_index == brd_pkg::REG_BLOCK_SIZE) ||
                              (cfg_index == brd_pkg::REG_REDUCE_MODE));

  always_comb begin
    if (tile_width == '0) w = (CW + 1)'(1);
    else if (32'(tile_width) > MAX_TILE_WIDTH) w = (CW + 1)'(MAX_TILE_WIDTH);
    else w = (CW + 1)'(tile_width);
    if (block_size == '0) bs = (BW + 1)'(1);
    else if (32'(block_size) > MAX_BLOCK) bs = (BW + 1)'(MAX_BLOCK);
    else bs = (BW + 1)'(block_size);
  end

  // w mod bs, one width bit per cycle, MSB first
  assign rem_bit = RIW'(rem_cnt - 1'b1);
  assign rem_trial = {rem_acc, w[rem_bit]};
  assign rem_sub = rem_trial - {1'b0, bs};

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      rem_busy <= 1'b1;
      rem_cnt <= RCW'(CW + 1);
      rem_acc <= '0;
    end else if (rem_busy) begin
      rem_acc <= (rem_trial >= {1'b0, bs}) ? rem_sub[BW:0] : rem_trial[BW:0];
      rem_cnt <= rem_cnt - 1'b1;
      if (rem_cnt == RCW'(1)) rem_busy <= 1'b0;
    end
  end
  assign bad_factor = (rem_acc != '0);

  brd_ctrl #(.MAX_TILE_WIDTH(MAX_TILE_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_hit), .cfg_busy(rem_busy), .w(w), .bs(bs),
    .bad_factor(bad_factor), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd), .oc(oc), .orow(orow)
  );

  brd_dpath #(
    .MAX_TILE_WIDTH(MAX_TILE_WIDTH), .MAX_BLOCK(MAX_BLOCK), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dpath (
    .clk(clk), .rst(rst), .mode(reduce_mode), .bs(bs), .sample(sample), .cmd(cmd),
    .oc(oc), .orow(orow), .stat(stat), .reduced_value(reduced_value),
    .out_column(out_column), .out_row(out_row), .status(status), .last(last),
    .out_valid(out_valid), .out_stall(out_stall)
  );
endmodule
